@@ hdl/rfe_pkg.sv @@
package rfe_pkg;

   localparam int CSR_DATA_W = 32;
   localparam int CSR_INDEX_W = 1;

   localparam logic [1:0] OP_LOAD  = 2'd0;
   localparam logic [1:0] OP_RELOC = 2'd1;
   localparam logic [1:0] OP_READ  = 2'd2;

   localparam logic [CSR_INDEX_W-1:0] CSR_DELTA       = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_BYTES = 1'd1;

   localparam logic [15:0] ESCAPE_WORD = 16'h0001;

   localparam logic [1:0] ESC_NONE = 2'd0;
   localparam logic [1:0] ESC_HIGH = 2'd1;
   localparam logic [1:0] ESC_LOW  = 2'd2;

   typedef struct packed {
      logic [1:0]  operation;
      logic [14:0] addr;
      logic [15:0] data;
      logic        last;
   } req_type;

   typedef struct packed {
      logic [15:0] read_data;
      logic        status;
      logic        table_done;
   } rsp_type;

endpackage

@@ hdl/relocation_fixup_engine.sv @@
// Relocation fixup engine: a program image sits in an on-chip halfword memory (one read port
// with registered data, one write port) and a delta-encoded relocation table streamed in as
// requests patches it in place by the delta register. Every request yields one response.
// Image loads, unused operations and relocation words that patch nothing (zero delta, sticky
// error, the escape word or the displacement's high word) finish in the execute state, so they
// stream back to back. An image read then passes a read state; a patching word passes the
// bounds check, where a failing patch ends, and then patches a 16-bit word in a write state or
// a 32-bit word in low read, low write and high write states. The sequencer walks the memory
// ports: the bounds check, then one registered read per halfword and one write per halfword,
// the low half first so its carry reaches the high half. A new request is taken while idle or
// in the cycle a response moves into the output register, which needs that register empty or
// being emptied; a stalled response holds the engine in place and stalls the input. The memory
// is not cleared after reset.
module relocation_fixup_engine
   import rfe_pkg::*;
#(
   parameter int IMAGE_BYTES = 65536
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  req_type                req_payload,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsp_type                rsp_payload,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_write_data
);

   localparam int DEPTH = IMAGE_BYTES / 2;
   localparam int AW = $clog2(DEPTH);
   localparam logic [32:0] STORE_BYTES = 33'(IMAGE_BYTES);

   typedef enum logic [8:0] {
      ST_IDLE        = 9'b000000001,
      ST_EXEC        = 9'b000000010,
      ST_READ        = 9'b000000100,
      ST_CHECK       = 9'b000001000,
      ST_ODD_WR      = 9'b000010000,
      ST_EVEN_LO_RD  = 9'b000100000,
      ST_EVEN_LO_WR  = 9'b001000000,
      ST_EVEN_HI_WR  = 9'b010000000,
      ST_HOLD        = 9'b100000000
   } state_type;

   logic [15:0] image_mem [DEPTH];

   state_type   state_ff, state_in;
   req_type     work_ff, work_in;
   rsp_type     res_ff, res_in;
   rsp_type     rsp_ff, rsp_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] offset_ff, offset_in;
   logic        first_ff, first_in;
   logic [1:0]  esc_ff, esc_in;
   logic [15:0] disp_high_ff, disp_high_in;
   logic        error_ff, error_in;
   logic [15:0] hi_ff, hi_in;
   logic        carry_ff, carry_in;
   logic [31:0] delta_ff;
   logic [16:0] image_bytes_ff;
   logic [15:0] mem_rdata_ff;

   logic          mem_we;
   logic [AW-1:0] mem_waddr;
   logic [AW-1:0] mem_raddr;
   logic [15:0]   mem_wdata;

   logic          finish_now;
   logic          finish_go;
   logic          out_free;
   logic          req_accept;
   logic          delta_nz;
   logic          do_patch;
   logic          load_in_range;
   logic [31:0]   addr_wide;
   logic [AW-1:0] item_addr;
   logic [AW-1:0] idx;
   logic [AW-1:0] idx_next;
   logic [31:0]   addend;
   logic [32:0]   limit;
   logic [32:0]   patch_end;
   logic          breach;
   logic [16:0]   sum_lo;
   rsp_type       res_calc;

   assign out_free      = !rsp_valid_ff || !rsp_stall;
   assign delta_nz      = (delta_ff != 32'd0);
   assign addr_wide     = 32'(work_ff.addr);
   assign item_addr     = addr_wide[AW-1:0];
   assign load_in_range = addr_wide < 32'(DEPTH);
   assign idx           = offset_ff[AW:1];
   assign idx_next      = idx + AW'(1);
   assign addend        = (esc_ff == ESC_LOW) ? {disp_high_ff, work_ff.data}
                                              : {16'd0, work_ff.data};
   // patches may not reach past the smaller of the region register and the store
   assign limit     = ({16'd0, image_bytes_ff} > STORE_BYTES) ? STORE_BYTES
                                                              : {16'd0, image_bytes_ff};
   assign patch_end = {1'b0, offset_ff[31:1], 1'b0} + (offset_ff[0] ? 33'd2 : 33'd4);
   assign breach    = patch_end > limit;

   always_comb begin
      state_in     = state_ff;
      offset_in    = offset_ff;
      first_in     = first_ff;
      esc_in       = esc_ff;
      disp_high_in = disp_high_ff;
      error_in     = error_ff;
      hi_in        = hi_ff;
      carry_in     = carry_ff;
      res_in       = res_ff;
      mem_we       = 1'b0;
      mem_waddr    = idx;
      mem_raddr    = idx;
      mem_wdata    = 16'd0;
      finish_now   = 1'b0;
      do_patch     = 1'b0;
      sum_lo       = 17'd0;
      res_calc     = '0;

      unique case (state_ff)
         ST_IDLE: begin
         end
         ST_EXEC: begin
            mem_raddr = item_addr;
            case (work_ff.operation)
               OP_LOAD: begin
                  mem_we     = load_in_range;
                  mem_waddr  = item_addr;
                  mem_wdata  = work_ff.data;
                  finish_now = 1'b1;
               end
               OP_READ: begin
                  state_in = ST_READ;
               end
               OP_RELOC: begin
                  if (!error_ff) begin
                     if (esc_ff == ESC_HIGH) begin
                        disp_high_in = work_ff.data;
                        esc_in       = ESC_LOW;
                        error_in     = work_ff.last && delta_nz;
                     end else if (esc_ff == ESC_LOW) begin
                        offset_in = offset_ff + addend;
                        esc_in    = ESC_NONE;
                        do_patch  = 1'b1;
                     end else if (first_ff) begin
                        offset_in = {16'd0, work_ff.data};
                        first_in  = 1'b0;
                        do_patch  = 1'b1;
                     end else if (work_ff.data == ESCAPE_WORD) begin
                        esc_in   = ESC_HIGH;
                        error_in = work_ff.last && delta_nz;
                     end else begin
                        offset_in = offset_ff + addend;
                        do_patch  = 1'b1;
                     end
                  end
                  // a zero delta leaves the image as it is, so the patch is skipped
                  if (do_patch && delta_nz) begin
                     state_in = ST_CHECK;
                  end else begin
                     finish_now = 1'b1;
                  end
               end
               default: begin
                  finish_now = 1'b1;
               end
            endcase
         end
         ST_READ: begin
            res_calc.read_data = load_in_range ? mem_rdata_ff : 16'd0;
            finish_now         = 1'b1;
         end
         ST_CHECK: begin
            if (breach) begin
               error_in   = 1'b1;
               finish_now = 1'b1;
            end else begin
               state_in = offset_ff[0] ? ST_ODD_WR : ST_EVEN_LO_RD;
            end
         end
         ST_ODD_WR: begin
            mem_we     = 1'b1;
            mem_wdata  = mem_rdata_ff + delta_ff[15:0];
            finish_now = 1'b1;
         end
         ST_EVEN_LO_RD: begin
            hi_in     = mem_rdata_ff;
            mem_raddr = idx_next;
            state_in  = ST_EVEN_LO_WR;
         end
         ST_EVEN_LO_WR: begin
            sum_lo    = {1'b0, mem_rdata_ff} + {1'b0, delta_ff[15:0]};
            mem_we    = 1'b1;
            mem_waddr = idx_next;
            mem_wdata = sum_lo[15:0];
            carry_in  = sum_lo[16];
            state_in  = ST_EVEN_HI_WR;
         end
         ST_EVEN_HI_WR: begin
            mem_we     = 1'b1;
            mem_wdata  = hi_ff + delta_ff[31:16] + 16'(carry_ff);
            finish_now = 1'b1;
         end
         ST_HOLD: begin
            finish_now = 1'b1;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      res_calc.status     = error_in;
      res_calc.table_done = (work_ff.operation == OP_RELOC) && work_ff.last;

      if (finish_now && state_ff != ST_HOLD) begin
         res_in = res_calc;
         // end of table puts the parser back to its initial state
         if (work_ff.operation == OP_RELOC && work_ff.last) begin
            offset_in    = 32'd0;
            first_in     = 1'b1;
            esc_in       = ESC_NONE;
            disp_high_in = 16'd0;
            error_in     = 1'b0;
         end
      end

      if (finish_now) begin
         if (!out_free) begin
            state_in = ST_HOLD;
         end else begin
            state_in = req_valid ? ST_EXEC : ST_IDLE;
         end
      end else if (state_ff == ST_IDLE) begin
         state_in = req_valid ? ST_EXEC : ST_IDLE;
      end
   end

   assign finish_go  = finish_now && out_free;
   assign req_stall  = !((state_ff == ST_IDLE) || finish_go);
   assign req_accept = req_valid && !req_stall;
   assign work_in    = req_accept ? req_payload : work_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      if (finish_go) begin
         rsp_valid_in = 1'b1;
         rsp_in       = (state_ff == ST_HOLD) ? res_ff : res_calc;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         image_mem[mem_waddr] <= mem_wdata;
      end
      mem_rdata_ff <= image_mem[mem_raddr];
   end

   always_ff @(posedge clock) begin
      work_ff  <= work_in;
      res_ff   <= res_in;
      rsp_ff   <= rsp_in;
      hi_ff    <= hi_in;
      carry_ff <= carry_in;
      if (reset) begin
         state_ff       <= ST_IDLE;
         rsp_valid_ff   <= 1'b0;
         offset_ff      <= 32'd0;
         first_ff       <= 1'b1;
         esc_ff         <= ESC_NONE;
         disp_high_ff   <= 16'd0;
         error_ff       <= 1'b0;
         delta_ff       <= 32'd0;
         image_bytes_ff <= 17'd0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         offset_ff    <= offset_in;
         first_ff     <= first_in;
         esc_ff       <= esc_in;
         disp_high_ff <= disp_high_in;
         error_ff     <= error_in;
         if (csr_write_enable) begin
            unique case (csr_index)
               CSR_DELTA:       delta_ff <= csr_write_data;
               CSR_IMAGE_BYTES: image_bytes_ff <= csr_write_data[16:0];
               default: begin
               end
            endcase
         end
      end
   end

`ifndef NO_ASSERTIONS
   a_accept_starts_exec: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> state_ff == ST_EXEC)
      else $error("accepted request did not start execution");

   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(finish_go))
      else $error("response appeared without a finished request");

   a_error_needs_delta: assert property (@(posedge clock) disable iff (reset)
      $rose(error_ff) |-> delta_ff != 32'd0)
      else $error("table error raised with zero delta");

   a_hold_means_full: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_HOLD |-> rsp_valid_ff)
      else $error("result held while output register empty");

   a_even_patch_order: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EVEN_HI_WR |-> $past(state_ff) == ST_EVEN_LO_WR)
      else $error("high half written before low half");
`endif

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
   import rfe_pkg::*;

   localparam int STORE_BYTES = 65536;
   localparam int STORE_HALFWORDS = STORE_BYTES / 2;
   localparam logic [1:0] OP_SPARE = 2'd3;
   localparam int QUIET_LIMIT = 400;
   localparam int PHASE_BUDGET = 90;

   logic clock;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_type req_payload = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_type rsp_payload;
   logic csr_write_enable = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_write_data = '0;

   relocation_fixup_engine #(.IMAGE_BYTES(STORE_BYTES)) DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_payload(req_payload),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_payload(rsp_payload),
      .csr_write_enable(csr_write_enable),
      .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // shadow of the engine state
   logic [15:0] shadow_image [STORE_HALFWORDS];
   logic [31:0] cur_offset = '0;
   logic at_table_start = 1'b1;
   logic [1:0] esc_state = ESC_NONE;
   logic [15:0] disp_upper = '0;
   logic reject_flag = 1'b0;
   logic [31:0] delta_reg = '0;
   logic [16:0] size_reg = '0;

   req_type pending_req [$];
   rsp_type awaited_rsp [$];

   // stimulus-side bookkeeping of loaded halfwords
   bit written [STORE_HALFWORDS];
   logic [14:0] loaded_idx [$];
   longint unsigned gen_bound = 0;

   int reqs_queued = 0;
   int reqs_taken = 0;
   int rsps_seen = 0;
   int tables_seen = 0;
   int tables_rejected = 0;
   int mismatches = 0;
   int settings_used = 0;
   int send_gap = 0;
   int send_calm = 0;
   int hold_left = 0;
   int recv_calm = 0;
   int quiet_cycles = 0;

   function automatic int draw_wait(inout int calm);
      if (calm > 0) begin
         calm--;
         return 0;
      end
      if ($urandom_range(0, 9) == 0) calm = $urandom_range(8, 40);
      return $urandom_range(0, 17);
   endfunction

   task automatic apply_patch();
      logic [32:0] span_limit;
      logic [32:0] span_end;
      logic [14:0] hi_idx;
      logic [14:0] lo_idx;
      logic [31:0] joined;
      span_limit = (size_reg > STORE_BYTES) ? 33'(STORE_BYTES) : 33'(size_reg);
      hi_idx = cur_offset[15:1];
      lo_idx = hi_idx + 15'd1;
      if (cur_offset[0]) begin
         span_end = {1'b0, cur_offset[31:1], 1'b0} + 33'd2;
         if (span_end > span_limit) begin
            reject_flag = 1'b1;
         end else begin
            shadow_image[hi_idx] = shadow_image[hi_idx] + delta_reg[15:0];
         end
      end else begin
         span_end = {1'b0, cur_offset} + 33'd4;
         if (span_end > span_limit) begin
            reject_flag = 1'b1;
         end else begin
            joined = {shadow_image[hi_idx], shadow_image[lo_idx]} + delta_reg;
            shadow_image[hi_idx] = joined[31:16];
            shadow_image[lo_idx] = joined[15:0];
         end
      end
   endtask

   task automatic parse_word(input logic [15:0] w, input logic eot);
      logic go;
      go = 1'b0;
      case (esc_state)
         ESC_HIGH: begin
            disp_upper = w;
            esc_state = ESC_LOW;
            if (eot) reject_flag = 1'b1;
         end
         ESC_LOW: begin
            cur_offset = cur_offset + {disp_upper, w};
            esc_state = ESC_NONE;
            go = 1'b1;
         end
         default: begin
            esc_state = ESC_NONE;
            if (at_table_start) begin
               // first word is always absolute, even when it equals the escape code
               cur_offset = {16'h0, w};
               at_table_start = 1'b0;
               go = 1'b1;
            end else if (w == ESCAPE_WORD) begin
               esc_state = ESC_HIGH;
               if (eot) reject_flag = 1'b1;
            end else begin
               cur_offset = cur_offset + {16'h0, w};
               go = 1'b1;
            end
         end
      endcase
      if (go) apply_patch();
   endtask

   task automatic relocate_step(input req_type r, output rsp_type o);
      logic saved;
      o = '0;
      case (r.operation)
         OP_LOAD: shadow_image[r.addr] = r.data;
         OP_READ: o.read_data = shadow_image[r.addr];
         OP_RELOC: begin
            saved = reject_flag;
            if (!reject_flag) parse_word(r.data, r.last);
            // zero delta never rejects
            if (delta_reg == '0) reject_flag = saved;
            o.table_done = r.last;
         end
         default: ;
      endcase
      o.status = reject_flag;
      if (r.operation == OP_RELOC && r.last) begin
         cur_offset = '0;
         at_table_start = 1'b1;
         esc_state = ESC_NONE;
         disp_upper = '0;
         reject_flag = 1'b0;
      end
   endtask

   task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
      mismatches++;
      if (mismatches <= 100)
         $display("mismatch on %s at response %0d: got %h, predicted %h",
                  what, rsps_seen, got, want);
   endtask

   always @(posedge clock) begin : send_req
      rsp_type predicted;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            relocate_step(req_payload, predicted);
            awaited_rsp.push_back(predicted);
            reqs_taken++;
         end
         if (!req_valid || !req_stall) begin
            if (send_gap != 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (pending_req.size() != 0) begin
               req_payload <= pending_req.pop_front();
               req_valid <= 1'b1;
               send_gap = draw_wait(send_calm);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : watch_rsp
      rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            rsps_seen++;
            if (awaited_rsp.size() == 0) begin
               report("unexpected response", 32'(rsp_payload), '0);
            end else begin
               want = awaited_rsp.pop_front();
               if (rsp_payload.read_data !== want.read_data)
                  report("read_data", 32'(rsp_payload.read_data), 32'(want.read_data));
               if (rsp_payload.status !== want.status)
                  report("status", 32'(rsp_payload.status), 32'(want.status));
               if (rsp_payload.table_done !== want.table_done)
                  report("table_done", 32'(rsp_payload.table_done), 32'(want.table_done));
               if (want.table_done) begin
                  tables_seen++;
                  if (want.status) tables_rejected++;
               end
            end
            hold_left = draw_wait(recv_calm);
         end
         rsp_stall <= (hold_left != 0);
         if (hold_left != 0) hold_left--;
      end
   end

   always @(posedge clock) begin : watchdog
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("timeout: no handshake for %0d cycles", QUIET_LIMIT);
         $display("DONE: errors detected");
         $finish;
      end
   end

   task automatic push_req(input logic [1:0] op, input logic [14:0] a, input logic [15:0] d,
                           input logic eot);
      req_type r;
      r.operation = op;
      r.addr = a;
      r.data = d;
      r.last = eot;
      pending_req.push_back(r);
      reqs_queued++;
      if (op == OP_LOAD && !written[a]) begin
         written[a] = 1'b1;
         loaded_idx.push_back(a);
      end
   endtask

   function automatic logic [14:0] any_written();
      return loaded_idx[$urandom_range(0, loaded_idx.size() - 1)];
   endfunction

   // does a patch at this offset stay inside the current region
   function automatic bit fits(input logic [31:0] t);
      longint unsigned span_end;
      if (t[0]) span_end = 64'({t[31:1], 1'b0}) + 2;
      else span_end = 64'(t) + 4;
      return span_end <= gen_bound;
   endfunction

   // in-bound patches may only touch loaded halfwords
   function automatic bit safe(input logic [31:0] t);
      if (!fits(t)) return 1'b1;
      if (t[0]) return written[t[15:1]];
      return written[t[15:1]] && written[t[15:1] + 15'd1];
   endfunction

   function automatic logic [31:0] pick_target(input bit is_first);
      logic [31:0] t;
      int tries;
      if ($urandom_range(0, 4) != 0) begin
         for (tries = 0; tries < 8; tries++) begin
            t = {16'h0, any_written(), 1'($urandom_range(0, 1))};
            if (fits(t) && safe(t)) return t;
         end
      end
      case ($urandom_range(0, 3))
         0: t = 32'(gen_bound - 3 + $urandom_range(0, 4));
         1: t = 32'hFFFF_FFF0 | 32'($urandom_range(0, 15));
         2: t = $urandom;
         default: t = 32'(gen_bound + $urandom_range(0, 255));
      endcase
      if (is_first) t[31:16] = '0;
      if (!safe(t)) t = is_first ? 32'h0000_FFFE : 32'hFFFF_FFFE;
      return t;
   endfunction

   task automatic push_noise();
      case ($urandom_range(0, 9))
         0, 1, 2, 3: push_req(OP_LOAD, 15'($urandom), 16'($urandom), 1'($urandom));
         8: push_req(OP_SPARE, 15'($urandom), 16'($urandom), 1'($urandom));
         default: push_req(OP_READ, any_written(), 16'($urandom), 1'($urandom));
      endcase
   endtask

   task automatic push_table(input int n_targets, input bit broken);
      logic [31:0] t;
      logic [31:0] p;
      logic [31:0] d;
      logic eot;
      int k;
      p = '0;
      for (k = 0; k < n_targets; k++) begin
         if ($urandom_range(0, 7) == 0) push_noise();
         t = pick_target(k == 0);
         eot = (k == n_targets - 1) && !broken;
         d = t - p;
         if (k == 0) begin
            push_req(OP_RELOC, 15'($urandom), t[15:0], eot);
         end else if (d[31:16] == '0 && d[15:0] != ESCAPE_WORD && $urandom_range(0, 4) != 0) begin
            push_req(OP_RELOC, 15'($urandom), d[15:0], eot);
         end else begin
            push_req(OP_RELOC, 15'($urandom), ESCAPE_WORD, 1'b0);
            push_req(OP_RELOC, 15'($urandom), d[31:16], 1'b0);
            push_req(OP_RELOC, 15'($urandom), d[15:0], eot);
         end
         p = t;
      end
      // table cut off inside an escape sequence
      if (broken) begin
         eot = 1'($urandom);
         push_req(OP_RELOC, 15'($urandom), ESCAPE_WORD, eot);
         if (!eot) push_req(OP_RELOC, 15'($urandom), 16'($urandom), 1'b1);
      end
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (pending_req.size() != 0 || req_valid || awaited_rsp.size() != 0);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [31:0] val);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= val;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      if (idx == CSR_DELTA) delta_reg = val;
      else if (idx == CSR_IMAGE_BYTES) size_reg = val[16:0];
   endtask

   task automatic set_registers(input logic [31:0] dlt, input logic [16:0] bytes);
      wait_drained();
      write_reg(CSR_DELTA, dlt);
      write_reg(CSR_IMAGE_BYTES, 32'(bytes));
      gen_bound = (bytes > STORE_BYTES) ? STORE_BYTES : bytes;
      settings_used++;
   endtask

   task automatic run_phase(input logic [31:0] dlt, input logic [16:0] bytes);
      longint unsigned base;
      int k;
      int start;
      set_registers(dlt, bytes);
      // load a window, often right at the top of the region
      if (gen_bound / 2 > 14)
         base = $urandom_range(0, 1) ? gen_bound / 2 - 14 : $urandom_range(0, gen_bound / 2 - 14);
      else
         base = 0;
      for (k = 0; k < 14; k++)
         push_req(OP_LOAD, 15'(base + k), 16'($urandom), 1'($urandom));
      start = reqs_queued;
      while (reqs_queued - start < PHASE_BUDGET) begin
         case ($urandom_range(0, 9))
            0: push_noise();
            1: push_table($urandom_range(1, 4), 1'b1);
            default: push_table($urandom_range(1, 8), 1'b0);
         endcase
      end
   endtask

   initial begin : stimulus
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      set_registers(32'h0001_8001, 17'd16);
      push_req(OP_LOAD, 15'd0, 16'hFFFF, 1'b0);
      push_req(OP_LOAD, 15'd1, 16'h1234, 1'b1);
      push_req(OP_LOAD, 15'd2, 16'hFFFF, 1'b0);
      push_req(OP_LOAD, 15'd3, 16'h0000, 1'b1);
      push_req(OP_LOAD, 15'd4, 16'h8000, 1'b0);
      push_req(OP_LOAD, 15'd5, 16'h7FFF, 1'b0);
      push_req(OP_LOAD, 15'd6, 16'hFFFF, 1'b1);
      push_req(OP_LOAD, 15'd7, 16'hFFFE, 1'b0);
      push_req(OP_LOAD, 15'h7FFF, 16'hA5A5, 1'b1);
      push_req(OP_READ, 15'h7FFF, 16'hFFFF, 1'b1);
      push_req(OP_SPARE, 15'h7FFF, 16'hFFFF, 1'b1);
      // odd, odd, escape back by one to even with carry, even at the edge, breach, ignored
      push_req(OP_RELOC, 15'h0, ESCAPE_WORD, 1'b0);
      push_req(OP_RELOC, 15'h0, 16'h0002, 1'b0);
      push_req(OP_RELOC, 15'h0, ESCAPE_WORD, 1'b0);
      push_req(OP_RELOC, 15'h0, 16'hFFFF, 1'b0);
      push_req(OP_RELOC, 15'h0, 16'hFFFF, 1'b0);
      push_req(OP_RELOC, 15'h0, 16'h000A, 1'b0);
      push_req(OP_RELOC, 15'h0, 16'h0002, 1'b0);
      push_req(OP_RELOC, 15'h0, 16'h0004, 1'b1);
      push_req(OP_READ, 15'd1, 16'h0, 1'b0);
      push_req(OP_READ, 15'd2, 16'h0, 1'b0);
      // two tables ending inside an escape, then a one-word table
      push_req(OP_RELOC, 15'h0, 16'h0000, 1'b0);
      push_req(OP_RELOC, 15'h0, ESCAPE_WORD, 1'b1);
      push_req(OP_RELOC, 15'h0, 16'h0003, 1'b0);
      push_req(OP_RELOC, 15'h0, ESCAPE_WORD, 1'b0);
      push_req(OP_RELOC, 15'h0, 16'h0000, 1'b1);
      push_req(OP_RELOC, 15'h0, 16'hFFFF, 1'b1);

      run_phase(32'h0000_0000, 17'd200);
      run_phase(32'hFFFF_FFFF, 17'd65536);
      run_phase($urandom, 17'h1FFFF);
      run_phase($urandom, 17'd0);
      run_phase(32'h0000_0001, 17'($urandom_range(2, 600)));
      run_phase($urandom, 17'd65535);
      run_phase($urandom, 17'($urandom_range(0, 65536)));
      run_phase(32'h8000_0000, 17'($urandom_range(16, 4096)));

      wait_drained();
      repeat (20) @(posedge clock);
      $display("covered %0d requests and %0d responses across %0d register settings",
               reqs_taken, rsps_seen, settings_used);
      $display("relocation tables finished: %0d, of which %0d rejected",
               tables_seen, tables_rejected);
      if (mismatches == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
